// ----- design/lbd_pkg.sv -----
// Shared types, constants and neighbor tables for the lightmap border dilation block.
`default_nettype none

package lbd_pkg;

   // Default and field widths.
   localparam int MAX_SIDE_DEF = 512;
   localparam int CFG_W        = 10;
   localparam int COORD_W      = 9;
   localparam int TEXEL_W      = 32;
   localparam int ALPHA_W      = 8;
   localparam int SUM_W        = 11;
   localparam int CNT_W        = 4;
   localparam int REQ_DATA_W   = 56;
   localparam int RSP_DATA_W   = 56;
   localparam int CSR_INDEX_W  = 2;

   // Reset values of the configuration registers.
   localparam logic [CFG_W-1:0]   IMAGE_SIDE_RESET = 10'd512;
   localparam logic [ALPHA_W-1:0] ALPHA_THR_RESET  = 8'd254;

   // Number of neighbors around one texel.
   localparam logic [CNT_W-1:0] NBR_COUNT = 4'd8;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH     = 2'd0,
      CSR_HEIGHT    = 2'd1,
      CSR_THRESHOLD = 2'd2
   } csr_index_type;

   // Coordinate selectors: previous, own and next column or row.
   typedef enum logic [1:0] {
      SEL_LO  = 2'd0,
      SEL_MID = 2'd1,
      SEL_HI  = 2'd2
   } coord_sel_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_PREP,
      S_CHECK,
      S_GATHER,
      S_DIVIDE,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          capture;
      logic          prep;
      logic          mem_en;
      logic          mem_we;
      coord_sel_type col_sel;
      coord_sel_type row_sel;
      logic          keep_center;
      logic          accum;
      logic          div_step;
      logic [2:0]    div_bit;
      logic          out_load;
   } lbd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic center_empty;
      logic cnt_zero;
   } lbd_status_type;

   // Column selector of neighbor k, walking the 3x3 window without its center.
   function automatic coord_sel_type nbr_col_sel(input logic [2:0] k);
      coord_sel_type s;
      case (k)
         3'd0:    s = SEL_LO;
         3'd1:    s = SEL_MID;
         3'd2:    s = SEL_HI;
         3'd3:    s = SEL_LO;
         3'd4:    s = SEL_HI;
         3'd5:    s = SEL_LO;
         3'd6:    s = SEL_MID;
         3'd7:    s = SEL_HI;
         default: s = SEL_MID;
      endcase
      return s;
   endfunction

   // Row selector of neighbor k.
   function automatic coord_sel_type nbr_row_sel(input logic [2:0] k);
      coord_sel_type s;
      case (k)
         3'd0, 3'd1, 3'd2: s = SEL_LO;
         3'd3, 3'd4:       s = SEL_MID;
         3'd5, 3'd6, 3'd7: s = SEL_HI;
         default:          s = SEL_MID;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- design/lbd_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none

module lbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One access per cycle: write, or read into the output register.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/lbd_datapath.sv -----
// Datapath: configuration, coordinates, texel memory, neighbor sums and divider.
`default_nettype none

module lbd_datapath #(
   parameter int MAX_SIDE = lbd_pkg::MAX_SIDE_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lbd_pkg::lbd_cmd_type          cmd,
   output lbd_pkg::lbd_status_type            status,
   input  wire logic                          csr_wr_en,
   input  wire logic [lbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lbd_pkg::CFG_W-1:0]     csr_wdata,
   input  wire logic [lbd_pkg::COORD_W-1:0]   in_col,
   input  wire logic [lbd_pkg::COORD_W-1:0]   in_row,
   input  wire logic [lbd_pkg::TEXEL_W-1:0]   in_texel,
   output logic      [lbd_pkg::COORD_W-1:0]   out_col,
   output logic      [lbd_pkg::COORD_W-1:0]   out_row,
   output logic      [lbd_pkg::TEXEL_W-1:0]   out_texel,
   output logic                               out_filled
);

   import lbd_pkg::*;

   localparam int CW    = $clog2(MAX_SIDE);
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int WIDE  = (SW > CFG_W) ? SW : CFG_W;
   localparam int XW    = (CW > COORD_W) ? CW : COORD_W;
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);

   // Largest usable coordinate for a programmed side length.
   function automatic logic [CW-1:0] side_max(input logic [CFG_W-1:0] v);
      logic [WIDE-1:0] ve;
      logic [CW-1:0]   m;
      ve = WIDE'(v);
      if (ve == '0) begin
         m = '0;
      end else if (ve > WIDE'(MAX_SIDE)) begin
         m = CW'(MAX_SIDE - 1);
      end else begin
         m = CW'(ve - WIDE'(1));
      end
      return m;
   endfunction

   logic [CW-1:0]      wmax_ff, hmax_ff;
   logic [ALPHA_W-1:0] thr_ff;
   logic [CW-1:0]      col_ff, row_ff;
   logic [CW-1:0]      left_ff, right_ff, up_ff, down_ff;
   logic [TEXEL_W-1:0] texel_ff;
   logic [TEXEL_W-1:0] px_ff;
   logic [SUM_W-1:0]   sum_ff [3];
   logic [CNT_W-1:0]   cnt_ff;
   logic [7:0]         quo_ff [3];
   logic [COORD_W-1:0] rsp_col_ff, rsp_row_ff;
   logic [TEXEL_W-1:0] rsp_texel_ff;
   logic               rsp_filled_ff;

   logic [CW-1:0]      col_in, row_in;
   logic [CW-1:0]      col_pick, row_pick;
   logic [AW-1:0]      mem_addr;
   logic [TEXEL_W-1:0] rd_data;
   logic               qualify;
   logic [SUM_W-1:0]   trial;
   logic               filled_now;

   // Configuration registers; sides are kept as their largest coordinate.
   always_ff @(posedge clock) begin
      if (reset) begin
         wmax_ff <= side_max(IMAGE_SIDE_RESET);
         hmax_ff <= side_max(IMAGE_SIDE_RESET);
         thr_ff  <= ALPHA_THR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDTH:     wmax_ff <= side_max(csr_wdata);
            CSR_HEIGHT:    hmax_ff <= side_max(csr_wdata);
            CSR_THRESHOLD: thr_ff  <= csr_wdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the incoming coordinates to the image in use.
   always_comb begin
      col_in = (XW'(in_col) > XW'(wmax_ff)) ? wmax_ff : CW'(in_col);
      row_in = (XW'(in_row) > XW'(hmax_ff)) ? hmax_ff : CW'(in_row);
   end

   // Item capture and wrapped neighbor coordinates.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         texel_ff <= in_texel;
      end
      if (cmd.prep) begin
         left_ff  <= (col_ff == '0) ? wmax_ff : col_ff - CW'(1);
         right_ff <= (col_ff == wmax_ff) ? '0 : col_ff + CW'(1);
         up_ff    <= (row_ff == '0) ? hmax_ff : row_ff - CW'(1);
         down_ff  <= (row_ff == hmax_ff) ? '0 : row_ff + CW'(1);
      end
      if (cmd.keep_center) begin
         px_ff <= rd_data;
      end
   end

   // Memory address: the selected column and row of the 3x3 window.
   always_comb begin
      case (cmd.col_sel)
         SEL_LO:  col_pick = left_ff;
         SEL_HI:  col_pick = right_ff;
         default: col_pick = col_ff;
      endcase
      case (cmd.row_sel)
         SEL_LO:  row_pick = up_ff;
         SEL_HI:  row_pick = down_ff;
         default: row_pick = row_ff;
      endcase
      mem_addr = AW'(row_pick) * AW'(MAX_SIDE) + AW'(col_pick);
   end

   lbd_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (DEPTH)
   ) u_texel_ram (
      .clock (clock),
      .en    (cmd.mem_en),
      .we    (cmd.mem_we),
      .addr  (mem_addr),
      .wdata (texel_ff),
      .rdata (rd_data)
   );

   assign qualify = rd_data[TEXEL_W-1 -: ALPHA_W] > thr_ff;
   assign trial   = SUM_W'(cnt_ff) << cmd.div_bit;

   // Neighbor sums, which then serve as the divider remainders, one
   // quotient bit per lane each step.
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         cnt_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
            quo_ff[i] <= '0;
         end
      end else if (cmd.accum) begin
         if (qualify) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= sum_ff[i] + SUM_W'(rd_data[8*(2-i) +: 8]);
            end
         end
      end else if (cmd.div_step) begin
         for (int i = 0; i < 3; i++) begin
            if (sum_ff[i] >= trial) begin
               sum_ff[i]              <= sum_ff[i] - trial;
               quo_ff[i][cmd.div_bit] <= 1'b1;
            end
         end
      end
   end

   assign filled_now = (px_ff[TEXEL_W-1 -: ALPHA_W] == '0) && (cnt_ff != '0);

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_col_ff    <= COORD_W'(col_ff);
         rsp_row_ff    <= COORD_W'(row_ff);
         rsp_texel_ff  <= filled_now ? {thr_ff, quo_ff[0], quo_ff[1], quo_ff[2]} : px_ff;
         rsp_filled_ff <= filled_now;
      end
   end

   assign status.center_empty = (rd_data[TEXEL_W-1 -: ALPHA_W] == '0);
   assign status.cnt_zero     = (cnt_ff == '0);

   assign out_col    = rsp_col_ff;
   assign out_row    = rsp_row_ff;
   assign out_texel  = rsp_texel_ff;
   assign out_filled = rsp_filled_ff;

`ifndef ASSERT_OFF
   // While neighbors are summed or divided, at most eight can have qualified.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.accum || cmd.div_step |-> cnt_ff <= NBR_COUNT)
      else $error("neighbor count above eight");

   // A query result marked filled carries the threshold as its alpha.
   a_fill_alpha: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.out_load) && rsp_filled_ff |-> rsp_texel_ff[TEXEL_W-1 -: ALPHA_W] == thr_ff)
      else $error("filled texel without threshold alpha");
`endif

endmodule

`default_nettype wire

// ----- design/lbd_ctrl.sv -----
// Controller state machine: sequences loads, neighbor reads, division and result handoff.
`default_nettype none

module lbd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic                    req_action,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output lbd_pkg::lbd_cmd_type         cmd,
   input  wire lbd_pkg::lbd_status_type status
);

   import lbd_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [2:0]       bit_ff, bit_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.col_sel  = SEL_MID;
      cmd.row_sel  = SEL_MID;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = req_action ? S_PREP : S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.mem_en = 1'b1;
            cmd.mem_we = 1'b1;
            state_in   = S_IDLE;
         end
         S_PREP: begin
            // Neighbor coordinates are formed while the center is read.
            cmd.prep   = 1'b1;
            cmd.mem_en = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            cmd.keep_center = 1'b1;
            if (status.center_empty) begin
               cmd.mem_en  = 1'b1;
               cmd.col_sel = nbr_col_sel(3'd0);
               cmd.row_sel = nbr_row_sel(3'd0);
               k_in        = CNT_W'(1);
               state_in    = S_GATHER;
            end else begin
               state_in = S_DONE;
            end
         end
         S_GATHER: begin
            // Sum the neighbor read last cycle, read the next one.
            cmd.accum = 1'b1;
            if (k_ff == NBR_COUNT) begin
               bit_in   = 3'd7;
               state_in = S_DIVIDE;
            end else begin
               cmd.mem_en  = 1'b1;
               cmd.col_sel = nbr_col_sel(k_ff[2:0]);
               cmd.row_sel = nbr_row_sel(k_ff[2:0]);
               k_in        = k_ff + CNT_W'(1);
            end
         end
         S_DIVIDE: begin
            if (status.cnt_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.div_step = 1'b1;
               cmd.div_bit  = bit_ff;
               if (bit_ff == 3'd0) begin
                  state_in = S_DONE;
               end else begin
                  bit_in = bit_ff - 3'd1;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // A load item is written to memory in the cycle after it is taken.
   a_load_write: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_action |=> state_ff == S_WRITE)
      else $error("load item not followed by a write");

   // A query item starts its center read in the cycle after it is taken.
   a_query_prep: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_action |=> state_ff == S_PREP)
      else $error("query item not followed by a center read");

   // The neighbor counter stays within the window while gathering.
   a_gather_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GATHER |-> (k_ff >= CNT_W'(1)) && (k_ff <= NBR_COUNT))
      else $error("neighbor counter out of range");

   // The last divide step always leaves the divide state.
   a_divide_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIVIDE && bit_ff == 3'd0 |=> state_ff != S_DIVIDE)
      else $error("divider did not finish");
`endif

endmodule

`default_nettype wire

// ----- design/lightmap_border_dilation_core.sv -----
// A load item is taken in the idle state and written to the texel memory in the write state.
// A query on a texel with nonzero alpha reads and checks its center, then hands off its result.
// A query on an empty texel reads eight neighbors through the single memory port: with none
// qualifying no division is done, else eight one-bit divider steps follow before the result
// is valid. Items are handled one at a time; a second result waits in the controller until
// rsp_tready takes the first. Reset (synchronous, active high) clears control state and the
// configuration registers; the texel memory is not cleared.
`default_nettype none

module lightmap_border_dilation_core #(
   parameter int MAX_SIDE = lbd_pkg::MAX_SIDE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // req_tdata: col[8:0], row[17:9], texel_in[49:18], zero fill above.
   input  wire logic [lbd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: action (0 load, 1 query).
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // rsp_tdata: out_col[8:0], out_row[17:9], texel_out[49:18], zero fill above.
   output logic      [lbd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: filled.
   output logic                                 rsp_tuser,
   input  wire logic                            csr_wr_en,
   input  wire logic [lbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lbd_pkg::CFG_W-1:0]       csr_wdata
);

   import lbd_pkg::*;

   lbd_cmd_type        cmd;
   lbd_status_type     status;
   logic [COORD_W-1:0] out_col, out_row;
   logic [TEXEL_W-1:0] out_texel;

   lbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   lbd_datapath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_col     (req_tdata[COORD_W-1:0]),
      .in_row     (req_tdata[2*COORD_W-1:COORD_W]),
      .in_texel   (req_tdata[2*COORD_W+TEXEL_W-1:2*COORD_W]),
      .out_col    (out_col),
      .out_row    (out_row),
      .out_texel  (out_texel),
      .out_filled (rsp_tuser)
   );

   // Pack the result item, zero filled to whole bytes.
   assign rsp_tdata = RSP_DATA_W'({out_texel, out_row, out_col});

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking bench for the lightmap border dilation core: predicts every query and compares.

module tb;
   import lbd_pkg::*;

   localparam int SIDE = MAX_SIDE_DEF;

   typedef enum bit {
      ACT_LOAD  = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   // One expected query result.
   typedef struct {
      bit [8:0]  col;
      bit [8:0]  row;
      bit [31:0] texel;
      bit        filled;
   } dilated_texel;

   // Mirror of the texel image and registers; predicts and checks query results.
   class dilation_checker;
      bit [31:0]    image [SIDE*SIDE];
      bit [9:0]     width_reg;
      bit [9:0]     height_reg;
      bit [7:0]     thr_reg;
      dilated_texel awaited[$];
      int           mismatch_count;
      int           load_count;
      int           query_count;
      int           fill_count;

      function new();
         width_reg  = IMAGE_SIDE_RESET;
         height_reg = IMAGE_SIDE_RESET;
         thr_reg    = ALPHA_THR_RESET;
      endfunction

      // A side of zero acts as one; anything above the image limit acts as the limit.
      static function bit [9:0] used_side(bit [9:0] v);
         if (v == 0) return 10'd1;
         if (v > SIDE) return 10'(SIDE);
         return v;
      endfunction

      function void report(string what);
         mismatch_count++;
         $display("[%0t] MISMATCH: %s", $time, what);
      endfunction

      function void write_reg(csr_index_type idx, bit [9:0] value);
         case (idx)
            CSR_WIDTH:     width_reg = value;
            CSR_HEIGHT:    height_reg = value;
            CSR_THRESHOLD: thr_reg = value[7:0];
            default:       ;
         endcase
      endfunction

      // Applies a load to the image, or works out the dilated texel of a query.
      function void note_item(action_type act, bit [8:0] col, bit [8:0] row, bit [31:0] texel_in);
         bit [9:0]     w;
         bit [9:0]     h;
         bit [9:0]     c;
         bit [9:0]     r;
         bit [31:0]    nb;
         int           nc;
         int           nr;
         int           cnt;
         int           sr;
         int           sg;
         int           sbl;
         dilated_texel e;
         w = used_side(width_reg);
         h = used_side(height_reg);
         c = (col > w - 10'd1) ? w - 10'd1 : {1'b0, col};
         r = (row > h - 10'd1) ? h - 10'd1 : {1'b0, row};
         if (act == ACT_LOAD) begin
            image[r*SIDE + c] = texel_in;
            load_count++;
            return;
         end
         query_count++;
         e.col    = c[8:0];
         e.row    = r[8:0];
         e.texel  = image[r*SIDE + c];
         e.filled = 1'b0;
         cnt = 0;
         sr  = 0;
         sg  = 0;
         sbl = 0;
         // Empty texel: average the qualifying neighbors, wrapping at the image edges.
         if (e.texel[31:24] == 0) begin
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr == 0 && dc == 0) continue;
                  nc = (int'(c) + dc + int'(w)) % int'(w);
                  nr = (int'(r) + dr + int'(h)) % int'(h);
                  nb = image[nr*SIDE + nc];
                  if (nb[31:24] > thr_reg) begin
                     sr  += nb[23:16];
                     sg  += nb[15:8];
                     sbl += nb[7:0];
                     cnt++;
                  end
               end
            end
            if (cnt != 0) begin
               e.texel  = {thr_reg, 8'(sr / cnt), 8'(sg / cnt), 8'(sbl / cnt)};
               e.filled = 1'b1;
               fill_count++;
            end
         end
         awaited = {awaited, e};
      endfunction

      // Compares one returned result with the oldest expected one.
      function void check_result(bit [RSP_DATA_W-1:0] data, bit filled);
         dilated_texel e;
         if (awaited.size() == 0) begin
            report($sformatf("result for col %0d row %0d with no query waiting",
                             data[8:0], data[17:9]));
            return;
         end
         e = awaited.pop_front();
         if (data[8:0] != e.col)
            report($sformatf("out_col %0d, expected %0d", data[8:0], e.col));
         if (data[17:9] != e.row)
            report($sformatf("out_row %0d, expected %0d", data[17:9], e.row));
         if (data[49:18] != e.texel)
            report($sformatf("texel_out %h at (%0d,%0d), expected %h",
                             data[49:18], e.col, e.row, e.texel));
         if (filled != e.filled)
            report($sformatf("filled %0b at (%0d,%0d), expected %0b",
                             filled, e.col, e.row, e.filled));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   dilation_checker dilation = new();

   // Stimulus-side view of the configuration and of which texels hold data.
   bit       texel_loaded [SIDE*SIDE];
   bit [9:0] cfg_w;
   bit [9:0] cfg_h;
   bit [7:0] cfg_thr;
   bit       steady;
   int       rsp_hold;
   int       config_count;

   lightmap_border_dilation_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Mostly no gap, some short gaps, a few long ones; none in steady stretches.
   function automatic int pick_gap();
      int pick;
      if (steady) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side back-pressure.
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_hold   <= pick_gap();
         rsp_tready <= 1'b1;
      end
   end

   // Observe accepted items, register writes and results.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            dilation.write_reg(csr_index_type'(csr_index), csr_wdata);
         if (req_tvalid && req_tready)
            dilation.note_item(action_type'(req_tuser), req_tdata[8:0], req_tdata[17:9],
                               req_tdata[49:18]);
         if (rsp_tvalid && rsp_tready)
            dilation.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Offers one item after a random gap and returns once it is taken.
   task automatic send_item(action_type act, bit [8:0] col, bit [8:0] row, bit [31:0] texel);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_DATA_W-50){1'b0}}, texel, row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Loads a texel and marks its saturated position as holding data.
   task automatic load_texel(bit [8:0] col, bit [8:0] row, bit [31:0] texel);
      bit [9:0] w;
      bit [9:0] h;
      bit [9:0] c;
      bit [9:0] r;
      w = dilation_checker::used_side(cfg_w);
      h = dilation_checker::used_side(cfg_h);
      c = (col > w - 10'd1) ? w - 10'd1 : {1'b0, col};
      r = (row > h - 10'd1) ? h - 10'd1 : {1'b0, row};
      texel_loaded[r*SIDE + c] = 1'b1;
      send_item(ACT_LOAD, col, row, texel);
   endtask

   // Waits until every expected result is back, then lets the block settle.
   // The first edge lets the monitor note the item taken at the last edge.
   task automatic drain();
      int waited;
      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (dilation.awaited.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      if (dilation.awaited.size() != 0) begin
         dilation.report($sformatf("%0d query results never came", dilation.awaited.size()));
         dilation.awaited.delete();
      end
      repeat (24) @(posedge clock);
   endtask

   // Writes all three registers while the block is idle.
   task automatic configure(bit [9:0] w, bit [9:0] h, bit [7:0] thr);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= {2'b00, thr};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_w   = w;
      cfg_h   = h;
      cfg_thr = thr;
      config_count++;
   endtask

   // Alpha is biased toward empty texels and values around the threshold.
   function automatic bit [31:0] make_texel();
      bit [7:0] a;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      a = 8'h00;
      else if (pick < 45) a = cfg_thr;
      else if (pick < 55) a = (cfg_thr == 8'hFF) ? 8'hFF : cfg_thr + 8'd1;
      else if (pick < 70) a = 8'hFF;
      else                a = 8'($urandom_range(0, 255));
      return {a, 24'($urandom)};
   endfunction

   // Mostly coordinates inside the image, sometimes anywhere in the field range.
   function automatic bit [8:0] pick_coord(bit [9:0] used);
      if ($urandom_range(0, 4) == 0) return 9'($urandom_range(0, 511));
      return 9'($urandom_range(0, used - 1));
   endfunction

   // Every texel of the image in use gets data before any query can read it.
   task automatic fill_image();
      bit [9:0] w;
      bit [9:0] h;
      w = dilation_checker::used_side(cfg_w);
      h = dilation_checker::used_side(cfg_h);
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++)
            if (!texel_loaded[r*SIDE + c])
               load_texel(9'(c), 9'(r), make_texel());
   endtask

   // One setting: configure, fill the image, then a random mix of loads and queries.
   task automatic run_phase(bit [9:0] w, bit [9:0] h, bit [7:0] thr, int n, bit calm);
      bit [9:0] uw;
      bit [9:0] uh;
      configure(w, h, thr);
      steady = calm;
      fill_image();
      uw = dilation_checker::used_side(w);
      uh = dilation_checker::used_side(h);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0)
            load_texel(pick_coord(uw), pick_coord(uh), make_texel());
         else
            send_item(ACT_QUERY, pick_coord(uw), pick_coord(uh), $urandom);
      end
      steady = 1'b0;
   endtask

   // Oversized one-texel-thin image: only both ends of the long side are used, so
   // queries at 0, 1, 510 and 511 see just the six loaded texels there.
   task automatic edge_phase(bit wide, bit [7:0] thr, int n);
      bit [8:0] ends [6];
      bit [8:0] pos;
      ends = '{9'd0, 9'd1, 9'd510, 9'd511, 9'd2, 9'd509};
      if (wide) configure(10'd1023, 10'd1, thr);
      else      configure(10'd1, 10'd1023, thr);
      foreach (ends[i]) begin
         if (wide) load_texel(ends[i], 9'($urandom_range(0, 511)), make_texel());
         else      load_texel(9'($urandom_range(0, 511)), ends[i], make_texel());
      end
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) begin
            pos = ends[$urandom_range(0, 5)];
            if (wide) load_texel(pos, 9'($urandom_range(0, 511)), make_texel());
            else      load_texel(9'($urandom_range(0, 511)), pos, make_texel());
         end else begin
            pos = ends[$urandom_range(0, 3)];
            if (wide) send_item(ACT_QUERY, pos, 9'($urandom_range(0, 511)), $urandom);
            else      send_item(ACT_QUERY, 9'($urandom_range(0, 511)), pos, $urandom);
         end
      end
   endtask

   // Run time limit.
   initial begin
      #(20 * 1_000_000);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      rsp_hold   = 0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_WIDTH;
      csr_wdata  = '0;
      steady     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a 3x3 image with wrap, threshold edges and saturated coordinates.
      configure(10'd3, 10'd3, 8'd100);
      load_texel(9'd0, 9'd0, 32'h65FF0010);
      load_texel(9'd1, 9'd0, 32'h64123456);
      load_texel(9'd2, 9'd0, 32'hFFFFFFFF);
      load_texel(9'd0, 9'd1, 32'h00AABBCC);
      load_texel(9'd1, 9'd1, 32'h00000000);
      load_texel(9'd2, 9'd1, 32'h80010203);
      load_texel(9'd0, 9'd2, 32'h00000000);
      load_texel(9'd1, 9'd2, 32'h01556677);
      load_texel(9'd511, 9'd511, 32'hC0102030);
      send_item(ACT_QUERY, 9'd1, 9'd1, 32'h0);
      send_item(ACT_QUERY, 9'd2, 9'd0, 32'hFFFFFFFF);
      send_item(ACT_QUERY, 9'd511, 9'd0, 32'h0);
      send_item(ACT_QUERY, 9'd0, 9'd1, 32'h0);
      send_item(ACT_QUERY, 9'd0, 9'd511, 32'h0);
      send_item(ACT_QUERY, 9'd1, 9'd2, 32'h0);
      // Zero threshold: any nonzero alpha qualifies and the filled alpha is zero.
      configure(10'd3, 10'd3, 8'd0);
      send_item(ACT_QUERY, 9'd1, 9'd1, 32'h0);
      send_item(ACT_QUERY, 9'd0, 9'd1, 32'h0);
      // Top threshold: no neighbor can qualify.
      configure(10'd3, 10'd3, 8'd255);
      send_item(ACT_QUERY, 9'd1, 9'd1, 32'h0);

      // Size extremes, then random small images.
      run_phase(10'd0, 10'd0, 8'($urandom_range(0, 255)), 40, 1'b0);
      edge_phase(1'b1, 8'($urandom_range(0, 254)), 40);
      edge_phase(1'b0, 8'($urandom_range(0, 254)), 40);
      for (int k = 0; k < 7; k++) begin
         run_phase(10'($urandom_range(1, 12)), 10'($urandom_range(1, 12)),
                   (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom_range(0, 254)),
                   50, k % 3 == 2);
      end

      drain();
      $display("Covered %0d loads and %0d queries, %0d of them filled from neighbors,",
               dilation.load_count, dilation.query_count, dilation.fill_count);
      $display("over %0d register settings including one-texel and full-width images.",
               config_count);
      if (dilation.mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- sim.f -----
design/lbd_pkg.sv
design/lbd_ram.sv
design/lbd_datapath.sv
design/lbd_ctrl.sv
design/lightmap_border_dilation_core.sv
test/tb.sv
